@@ src/muscl_minmod_rusanov_flux_assert.svh @@
// assertion macros for the muscl minmod rusanov flux block
// expects a clock named clk and a reset named rst in the including module
`ifndef MUSCL_MINMOD_RUSANOV_FLUX_ASSERT_SVH
`define MUSCL_MINMOD_RUSANOV_FLUX_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define MMRF_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("mmrf check failed");

// condition must hold in the cycle after the trigger
`define MMRF_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("mmrf check failed");

`endif

@@ src/mmrf_pkg.sv @@
// widths, types and helper functions for the muscl minmod rusanov flux block
// no dependencies
`default_nettype none

package mmrf_pkg;

  localparam int DW    = 32;           // data width of cell and flux fields
  localparam int FB    = 16;           // fraction bits
  localparam int CW    = 31;           // config register width
  localparam int IDX_W = 1;            // config index width
  localparam int SW    = DW + 2;       // interface state, one extra fraction bit
  localparam int BW    = ((SW > CW + 2) ? SW : CW + 2) + 1;
  localparam int AW    = ((SW > CW + 1) ? SW : CW + 1) + 2;
  localparam int DFW   = SW + 1;
  localparam int MPW   = BW + SW;
  localparam int SPW   = 2 * SW;
  localparam int APW   = AW + DFW;
  localparam int PW    = ((MPW > APW + 1) ? MPW : APW + 1) + 2;
  localparam int SH_M  = FB + 3;
  localparam int SH_T  = FB + 4;

  localparam logic [IDX_W-1:0] REG_BACKGROUND = 1'b0;
  localparam logic [IDX_W-1:0] REG_SOUND      = 1'b1;

  typedef logic signed [DW-1:0]  data_t;
  typedef logic signed [DW:0]    diff_t;
  typedef logic signed [SW-1:0]  state_t;
  typedef logic        [SW-1:0]  mag_t;
  typedef logic signed [BW-1:0]  bsum_t;
  typedef logic signed [AW-1:0]  alpha_t;
  typedef logic signed [DFW-1:0] diff2_t;
  typedef logic signed [MPW-1:0] mprod_t;
  typedef logic signed [SPW-1:0] sprod_t;
  typedef logic signed [APW-1:0] aprod_t;
  typedef logic signed [PW-1:0]  sum_t;
  typedef logic        [CW-1:0]  cfg_t;

  typedef struct packed {
    data_t n3, n2, n1, n0;
    data_t u3, u2, u1, u0;
    logic  has3, has2;
  } cells_t;

  typedef struct packed {
    state_t nl, ul, nr, ur;
  } iface_t;

  typedef struct packed {
    bsum_t  ml, mr;
    alpha_t al;
    state_t ul, ur;
    diff2_t dn, du;
  } terms_t;

  typedef struct packed {
    mprod_t pa, pb;
    sprod_t pc, pd;
    aprod_t pe, pf;
  } prods_t;

  typedef struct packed {
    data_t mass, mom;
  } flux_t;

  function automatic diff_t diff(data_t a, data_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  function automatic diff_t minmod(diff_t a, diff_t b);
    diff_t r;
    r = '0;
    if (a > 0 && b > 0) begin
      r = (a < b) ? a : b;
    end else if (a < 0 && b < 0) begin
      r = (a > b) ? a : b;
    end
    return r;
  endfunction

  function automatic mag_t mag(state_t a);
    return a[SW-1] ? mag_t'(~a + state_t'(1)) : mag_t'(a);
  endfunction

  function automatic data_t sat(sum_t x);
    data_t r;
    if (&x[PW-1:DW-1] || ~|x[PW-1:DW-1]) begin
      r = x[DW-1:0];
    end else if (x[PW-1]) begin
      r = {1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/muscl_minmod_rusanov_flux.sv @@
// muscl reconstruction with minmod slopes and rusanov interface fluxes
// depends on mmrf_pkg and muscl_minmod_rusanov_flux_assert.svh
`default_nettype none

// Cells of a grid row stream in one per cycle while in_stall is low. A cell
// arriving as the third or later cell of a row yields the flux of the interface
// two cells back; a cell marked last_cell also yields the flux between it and
// the previous cell, flagged by last_flux. Each cell passes through a five stage
// pipeline: input register, slopes and interface states, flux terms, products,
// then sum, shift and saturate into the output register. The output register
// sends one flux per cycle while out_stall is low, so a row end cell that yields
// two fluxes stalls input until the first of them is taken. Slopes of the first
// and last cell of a row are zero; the user must write config only while the
// block is idle, and the block itself does not enforce it.

`include "muscl_minmod_rusanov_flux_assert.svh"

module muscl_minmod_rusanov_flux (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_write,
  input  wire  [mmrf_pkg::IDX_W-1:0]       cfg_index,
  input  wire  [mmrf_pkg::CW-1:0]          cfg_data,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  signed [mmrf_pkg::DW-1:0]   cell_density,
  input  wire  signed [mmrf_pkg::DW-1:0]   cell_velocity,
  input  wire                              first_cell,
  input  wire                              last_cell,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic signed [mmrf_pkg::DW-1:0]   mass_flux,
  output logic signed [mmrf_pkg::DW-1:0]   momentum_flux,
  output logic                             last_flux
);
  import mmrf_pkg::*;

  cfg_t background_density;
  cfg_t sound_speed;

  data_t      wn [3];
  data_t      wu [3];
  logic [1:0] cells_seen;

  cells_t       c1;
  logic   [1:0] v1;
  iface_t [1:0] s2;
  logic   [1:0] v2;
  terms_t [1:0] t3;
  logic   [1:0] v3;
  prods_t [1:0] p4;
  logic   [1:0] v4;
  flux_t  [1:0] res;
  logic   [1:0] ov;

  logic         adv;
  logic         accept;
  logic         out_take;
  logic   [1:0] cnt;
  cells_t       c1_next;
  iface_t [1:0] s2_next;
  terms_t [1:0] t3_next;
  prods_t [1:0] p4_next;
  flux_t  [1:0] res_next;

  // whole pipeline moves while the output pair has room
  assign out_valid = ov[0] | ov[1];
  assign out_take  = out_valid & ~out_stall;
  assign adv       = ~out_valid | (out_take & ~(ov[0] & ov[1]));
  assign in_stall  = ~adv;
  assign accept    = in_valid & adv;

  assign mass_flux     = ov[0] ? res[0].mass : res[1].mass;
  assign momentum_flux = ov[0] ? res[0].mom  : res[1].mom;
  assign last_flux     = ~ov[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      background_density <= cfg_t'(65536);
      sound_speed        <= cfg_t'(65536);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BACKGROUND: background_density <= cfg_data;
        REG_SOUND:      sound_speed        <= cfg_data;
      endcase
    end
  end

  // window as seen by this cell, cleared by first_cell
  always_comb begin
    cnt          = first_cell ? 2'd0 : cells_seen;
    c1_next.n3   = wn[2];
    c1_next.n2   = wn[1];
    c1_next.n1   = wn[0];
    c1_next.n0   = cell_density;
    c1_next.u3   = wu[2];
    c1_next.u2   = wu[1];
    c1_next.u1   = wu[0];
    c1_next.u0   = cell_velocity;
    c1_next.has3 = (cnt == 2'd3);
    c1_next.has2 = (cnt >= 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_seen <= 2'd0;
    end else if (accept) begin
      if (last_cell) begin
        cells_seen <= 2'd0;
      end else begin
        cells_seen <= (cnt == 2'd3) ? 2'd3 : cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !last_cell) begin
      wn[2] <= wn[1];
      wn[1] <= wn[0];
      wn[0] <= cell_density;
      wu[2] <= wu[1];
      wu[1] <= wu[0];
      wu[0] <= cell_velocity;
    end
  end

  // slopes and interface states; lane 0 is the inner interface, lane 1 the row end
  always_comb begin
    diff_t sn2, su2, sn1, su1;
    sn2 = c1.has3 ? minmod(diff(c1.n2, c1.n3), diff(c1.n1, c1.n2)) : '0;
    su2 = c1.has3 ? minmod(diff(c1.u2, c1.u3), diff(c1.u1, c1.u2)) : '0;
    sn1 = c1.has2 ? minmod(diff(c1.n1, c1.n2), diff(c1.n0, c1.n1)) : '0;
    su1 = c1.has2 ? minmod(diff(c1.u1, c1.u2), diff(c1.u0, c1.u1)) : '0;
    s2_next[0].nl = (state_t'(c1.n2) <<< 1) + state_t'(sn2);
    s2_next[0].ul = (state_t'(c1.u2) <<< 1) + state_t'(su2);
    s2_next[0].nr = (state_t'(c1.n1) <<< 1) - state_t'(sn1);
    s2_next[0].ur = (state_t'(c1.u1) <<< 1) - state_t'(su1);
    s2_next[1].nl = (state_t'(c1.n1) <<< 1) + state_t'(sn1);
    s2_next[1].ul = (state_t'(c1.u1) <<< 1) + state_t'(su1);
    s2_next[1].nr = state_t'(c1.n0) <<< 1;
    s2_next[1].ur = state_t'(c1.u0) <<< 1;
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      mag_t ml, mr;
      ml = mag(s2[i].ul);
      mr = mag(s2[i].ur);
      t3_next[i].ml = bsum_t'({1'b0, background_density, 1'b0}) + bsum_t'(s2[i].nl);
      t3_next[i].mr = bsum_t'({1'b0, background_density, 1'b0}) + bsum_t'(s2[i].nr);
      t3_next[i].al = alpha_t'((ml > mr) ? ml : mr) + alpha_t'({sound_speed, 1'b0});
      t3_next[i].ul = s2[i].ul;
      t3_next[i].ur = s2[i].ur;
      t3_next[i].dn = diff2_t'(s2[i].nr) - diff2_t'(s2[i].nl);
      t3_next[i].du = diff2_t'(s2[i].ur) - diff2_t'(s2[i].ul);
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      p4_next[i].pa = mprod_t'(t3[i].ml) * mprod_t'(t3[i].ul);
      p4_next[i].pb = mprod_t'(t3[i].mr) * mprod_t'(t3[i].ur);
      p4_next[i].pc = sprod_t'(t3[i].ul) * sprod_t'(t3[i].ul);
      p4_next[i].pd = sprod_t'(t3[i].ur) * sprod_t'(t3[i].ur);
      p4_next[i].pe = aprod_t'(t3[i].al) * aprod_t'(t3[i].dn);
      p4_next[i].pf = aprod_t'(t3[i].al) * aprod_t'(t3[i].du);
    end
  end

  // momentum alpha term carries a factor of two, hence the extra shift
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sum_t s, t;
      s = sum_t'(p4[i].pa) + sum_t'(p4[i].pb) - sum_t'(p4[i].pe);
      t = sum_t'(p4[i].pc) + sum_t'(p4[i].pd) - (sum_t'(p4[i].pf) <<< 1);
      res_next[i].mass = sat(s >>> SH_M);
      res_next[i].mom  = sat(t >>> SH_T);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 2'b00;
      v2 <= 2'b00;
      v3 <= 2'b00;
      v4 <= 2'b00;
      ov <= 2'b00;
    end else if (adv) begin
      v1 <= accept ? {last_cell & (cnt != 2'd0), cnt >= 2'd2} : 2'b00;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      ov <= v4;
    end else if (out_take) begin
      ov[0] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1  <= c1_next;
      s2  <= s2_next;
      t3  <= t3_next;
      p4  <= p4_next;
      res <= res_next;
    end
  end

  // input stalls only behind a backlog at the output
  `MMRF_ASSERT_NOW(a_stall_needs_output, in_stall, out_valid)
  // a row end leaves an empty window
  `MMRF_ASSERT_NEXT(a_row_end_clears, accept && last_cell, cells_seen == 2'd0)
  // the inner interface always goes out before the row end one
  `MMRF_ASSERT_NOW(a_inner_first, ov[0], !last_flux)

endmodule

`default_nettype wire
